// ===== design/rbei_pkg.sv =====
// Shared types, constants and helper functions for the rigid body integrator.
// No dependencies; every other design file uses this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rbei_pkg;

   localparam int WORD_W    = 32;
   localparam int SCALE_W   = 31;
   localparam int DT_W      = 16;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 64;
   localparam int FRAC_W    = 16;
   localparam int NUM_AXES  = 3;
   localparam int AXIS_W    = 2;
   localparam int PHASE_W   = 2;

   localparam logic [SCALE_W-1:0] STATIC_LIMIT   = 31'd328;
   localparam logic [SCALE_W-1:0] INV_SCALE_RST  = 31'd65536;
   localparam logic [DT_W-1:0]    DAMP_Q16       = 16'd58982;
   localparam logic [PROD_W-1:0]  ROUND_HALF     = 64'd32768;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   // Axis slots of the state arrays.
   localparam logic [AXIS_W-1:0] AXIS_X   = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y   = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_ROT = 2'd2;

   // Step phases for one axis.
   localparam logic [PHASE_W-1:0] PH_SCALE = 2'd0;
   localparam logic [PHASE_W-1:0] PH_VEL   = 2'd1;
   localparam logic [PHASE_W-1:0] PH_POS   = 2'd2;
   // Impulse phases for one axis.
   localparam logic [PHASE_W-1:0] PH_DAMP  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_KICK  = 2'd1;

   localparam logic [AXIS_W-1:0]  AXIS_LAST_STEP  = AXIS_ROT;
   localparam logic [AXIS_W-1:0]  AXIS_LAST_IMP   = AXIS_Y;
   localparam logic [PHASE_W-1:0] PHASE_LAST_STEP = PH_POS;
   localparam logic [PHASE_W-1:0] PHASE_LAST_IMP  = PH_KICK;

   typedef enum logic [1:0] {
      ACT_FORCE   = 2'd0,
      ACT_TORQUE  = 2'd1,
      ACT_STEP    = 2'd2,
      ACT_IMPULSE = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_MASS    = 2'd0,
      CSR_INV_INERTIA = 2'd1,
      CSR_START_X     = 2'd2,
      CSR_START_Y     = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT,
      S_WB,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                capture;
      logic                wb;
      logic                load_rsp;
      logic                is_step;
      logic [AXIS_W-1:0]   axis;
      logic [PHASE_W-1:0]  phase;
   } seq_ctl_type;

   // Signed 32-bit add that clamps at the range limits.
   function automatic logic signed [WORD_W-1:0] sat_add(
      input logic signed [WORD_W-1:0] a,
      input logic signed [WORD_W-1:0] b
   );
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? WORD_MIN : WORD_MAX;
      end
      return s[WORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/rbei_req_if.sv =====
// Request channel interface: valid/ready handshake and the action payload.
// Depends on rbei_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rbei_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          action;
   logic signed [rbei_pkg::WORD_W-1:0]  vec_x;
   logic signed [rbei_pkg::WORD_W-1:0]  vec_y;
   logic signed [rbei_pkg::WORD_W-1:0]  torque_in;
   logic [rbei_pkg::DT_W-1:0]           time_step;

   modport source (output valid, action, vec_x, vec_y, torque_in, time_step, input ready);
   modport sink   (input valid, action, vec_x, vec_y, torque_in, time_step, output ready);
endinterface

`default_nettype wire

// ===== design/rbei_rsp_if.sv =====
// Response channel interface: valid/ready handshake and the body state payload.
// Depends on rbei_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rbei_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rbei_pkg::WORD_W-1:0]  pos_x;
   logic signed [rbei_pkg::WORD_W-1:0]  pos_y;
   logic signed [rbei_pkg::WORD_W-1:0]  angle;
   logic signed [rbei_pkg::WORD_W-1:0]  vel_x;
   logic signed [rbei_pkg::WORD_W-1:0]  vel_y;
   logic signed [rbei_pkg::WORD_W-1:0]  spin;
   logic                                is_static;

   modport source (output valid, pos_x, pos_y, angle, vel_x, vel_y, spin, is_static,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, angle, vel_x, vel_y, spin, is_static,
                   output ready);
endinterface

`default_nettype wire

// ===== design/rbei_mul.sv =====
// Shared Q16.16 multiplier: registered 32x32 product, then round and saturate.
// Depends on rbei_pkg. The product and the rounded result are each registered.
`timescale 1ns / 1ps
`default_nettype none

module rbei_mul (
   input  wire logic                                clock,
   input  wire logic signed [rbei_pkg::WORD_W-1:0]  op_a,
   input  wire logic [rbei_pkg::SCALE_W-1:0]        op_b,
   output logic signed [rbei_pkg::WORD_W-1:0]       result
);

   logic signed [rbei_pkg::PROD_W-1:0] prod_ff;
   logic signed [rbei_pkg::PROD_W-1:0] prod_in;
   logic signed [rbei_pkg::PROD_W-1:0] rnd;
   logic [rbei_pkg::PROD_W-rbei_pkg::WORD_W-rbei_pkg::FRAC_W:0] hi;
   logic signed [rbei_pkg::WORD_W-1:0] res_ff;
   logic signed [rbei_pkg::WORD_W-1:0] res_in;

   assign prod_in = $signed(op_a) * $signed({1'b0, op_b});

   // Add one half, then an arithmetic shift gives round half up.
   always_comb begin
      rnd = prod_ff + $signed(rbei_pkg::ROUND_HALF);
      hi  = rnd[rbei_pkg::PROD_W-1:rbei_pkg::WORD_W+rbei_pkg::FRAC_W-1];
      if ((hi == '0) || (hi == '1)) begin
         res_in = rnd[rbei_pkg::WORD_W+rbei_pkg::FRAC_W-1:rbei_pkg::FRAC_W];
      end else begin
         res_in = rnd[rbei_pkg::PROD_W-1] ? rbei_pkg::WORD_MIN : rbei_pkg::WORD_MAX;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// ===== design/rbei_seq.sv =====
// Sequencer for the integrator: walks axes and phases of step and impulse
// through the shared multiplier. Depends on rbei_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbei_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire rbei_pkg::action_type   req_action,
   input  wire logic                   body_static,
   input  wire logic                   rsp_free,
   output logic                        req_ready,
   output rbei_pkg::seq_ctl_type       ctl
);

   rbei_pkg::state_type               state_ff, state_in;
   logic [rbei_pkg::AXIS_W-1:0]       axis_ff, axis_in;
   logic [rbei_pkg::PHASE_W-1:0]      phase_ff, phase_in;
   logic                              step_mode_ff, step_mode_in;
   logic [rbei_pkg::AXIS_W-1:0]       last_axis;
   logic [rbei_pkg::PHASE_W-1:0]      last_phase;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbei_pkg::S_IDLE;
         axis_ff      <= rbei_pkg::AXIS_X;
         phase_ff     <= rbei_pkg::PH_SCALE;
         step_mode_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         phase_ff     <= phase_in;
         step_mode_ff <= step_mode_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      phase_in     = phase_ff;
      step_mode_in = step_mode_ff;
      req_ready    = 1'b0;
      ctl          = '0;
      ctl.is_step  = step_mode_ff;
      ctl.axis     = axis_ff;
      ctl.phase    = phase_ff;
      last_axis    = step_mode_ff ? rbei_pkg::AXIS_LAST_STEP : rbei_pkg::AXIS_LAST_IMP;
      last_phase   = step_mode_ff ? rbei_pkg::PHASE_LAST_STEP : rbei_pkg::PHASE_LAST_IMP;
      unique case (state_ff)
         rbei_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture  = 1'b1;
               axis_in      = rbei_pkg::AXIS_X;
               phase_in     = rbei_pkg::PH_SCALE;
               step_mode_in = (req_action == rbei_pkg::ACT_STEP);
               if (((req_action == rbei_pkg::ACT_STEP) ||
                    (req_action == rbei_pkg::ACT_IMPULSE)) && !body_static) begin
                  state_in = rbei_pkg::S_ISSUE;
               end else begin
                  state_in = rbei_pkg::S_DONE;
               end
            end
         end
         rbei_pkg::S_ISSUE: state_in = rbei_pkg::S_WAIT;
         rbei_pkg::S_WAIT:  state_in = rbei_pkg::S_WB;
         rbei_pkg::S_WB: begin
            ctl.wb = 1'b1;
            if (phase_ff == last_phase) begin
               phase_in = rbei_pkg::PH_SCALE;
               if (axis_ff == last_axis) begin
                  state_in = rbei_pkg::S_DONE;
               end else begin
                  axis_in  = axis_ff + rbei_pkg::AXIS_W'(1'b1);
                  state_in = rbei_pkg::S_ISSUE;
               end
            end else begin
               phase_in = phase_ff + rbei_pkg::PHASE_W'(1'b1);
               state_in = rbei_pkg::S_ISSUE;
            end
         end
         rbei_pkg::S_DONE: begin
            if (rsp_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = rbei_pkg::S_IDLE;
            end
         end
         default: state_in = rbei_pkg::S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/rigid_body_euler_integrator_core.sv =====
// Top level of the 2D rigid body semi-implicit Euler integrator (Q16.16).
// Depends on rbei_pkg, rbei_req_if, rbei_rsp_if, rbei_mul and rbei_seq.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transfer when          Carries
// --------  ---------  ---------------------  ----------------------------------------
// req_bus   in         valid && ready         action, vec_x, vec_y, torque_in, time_step
// rsp_bus   out        valid && ready         pos, angle, velocity, spin, is_static
// csr_*     in         csr_wr_en              inv_mass, inv_inertia, start_x, start_y
//
// Every product goes through one shared multiplier, used in turn to issue, round and
// write back, so the multiplier sets the rate. An impulse takes four products and a
// step nine; add force, add torque, and step or impulse on a static body take none.
// The block takes one request at a time; a result waits in an output register and the
// next request may be accepted while it waits. Reset is synchronous and active high
// and restores the body to rest at the origin with unit inverse mass and inertia.

module rigid_body_euler_integrator_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   rbei_req_if.sink                                  req_bus,
   rbei_rsp_if.source                                rsp_bus,
   input  wire logic                                 csr_wr_en,
   input  wire logic [rbei_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [rbei_pkg::WORD_W-1:0]          csr_wdata
);

   // Body state, indexed by axis: x, y, then rotation. The force sum of the rotation
   // slot is the torque accumulator, its velocity is spin and its position is angle.
   logic signed [rbei_pkg::WORD_W-1:0] pos_ff [rbei_pkg::NUM_AXES];
   logic signed [rbei_pkg::WORD_W-1:0] vel_ff [rbei_pkg::NUM_AXES];
   logic signed [rbei_pkg::WORD_W-1:0] frc_ff [rbei_pkg::NUM_AXES];
   logic [rbei_pkg::SCALE_W-1:0]       inv_mass_ff;
   logic [rbei_pkg::SCALE_W-1:0]       inv_inertia_ff;

   // Item operands and the intermediate product, held while the sequencer runs.
   logic signed [rbei_pkg::WORD_W-1:0] kick_ff [2];
   logic [rbei_pkg::DT_W-1:0]          dt_ff;
   logic signed [rbei_pkg::WORD_W-1:0] tmp_ff;

   logic                               rsp_valid_ff;
   logic signed [rbei_pkg::WORD_W-1:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_angle_ff;
   logic signed [rbei_pkg::WORD_W-1:0] rsp_vel_x_ff, rsp_vel_y_ff, rsp_spin_ff;
   logic                               rsp_static_ff;

   rbei_pkg::seq_ctl_type              ctl;
   rbei_pkg::action_type               req_action;
   logic                               body_static;
   logic                               rsp_free;
   logic                               req_fire;
   logic signed [rbei_pkg::WORD_W-1:0] op_a;
   logic [rbei_pkg::SCALE_W-1:0]       op_b;
   logic signed [rbei_pkg::WORD_W-1:0] mul_res;
   logic signed [rbei_pkg::WORD_W-1:0] add_a;
   logic signed [rbei_pkg::WORD_W-1:0] add_sum;

   assign req_action  = rbei_pkg::action_type'(req_bus.action);
   assign body_static = (inv_mass_ff < rbei_pkg::STATIC_LIMIT);
   assign rsp_free    = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire    = req_bus.valid && req_bus.ready;

   rbei_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_action  (req_action),
      .body_static (body_static),
      .rsp_free    (rsp_free),
      .req_ready   (req_bus.ready),
      .ctl         (ctl)
   );

   rbei_mul u_mul (
      .clock  (clock),
      .op_a   (op_a),
      .op_b   (op_b),
      .result (mul_res)
   );

   // Operand selection. A step axis runs: acceleration = force * inverse scale,
   // velocity += acceleration * dt, position += new velocity * dt. An impulse axis
   // runs: damped = velocity * 0.9, velocity = damped + impulse * inverse mass.
   always_comb begin
      op_a = tmp_ff;
      op_b = {{(rbei_pkg::SCALE_W-rbei_pkg::DT_W){1'b0}}, dt_ff};
      if (ctl.is_step) begin
         unique case (ctl.phase)
            rbei_pkg::PH_SCALE: begin
               op_a = frc_ff[ctl.axis];
               op_b = (ctl.axis == rbei_pkg::AXIS_ROT) ? inv_inertia_ff : inv_mass_ff;
            end
            rbei_pkg::PH_VEL: op_a = tmp_ff;
            default:          op_a = vel_ff[ctl.axis];
         endcase
      end else begin
         if (ctl.phase == rbei_pkg::PH_DAMP) begin
            op_a = vel_ff[ctl.axis];
            op_b = {{(rbei_pkg::SCALE_W-rbei_pkg::DT_W){1'b0}}, rbei_pkg::DAMP_Q16};
         end else begin
            op_a = kick_ff[ctl.axis[0]];
            op_b = inv_mass_ff;
         end
      end
   end

   // The single saturating adder used at write back.
   always_comb begin
      if (ctl.is_step) begin
         add_a = (ctl.phase == rbei_pkg::PH_POS) ? pos_ff[ctl.axis] : vel_ff[ctl.axis];
      end else begin
         add_a = tmp_ff;
      end
      add_sum = rbei_pkg::sat_add(add_a, mul_res);
   end

   // Body state and configuration. Configuration must be written only while idle, which the
   // block does not enforce; a start position write loads the matching position at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rbei_pkg::NUM_AXES; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            frc_ff[i] <= '0;
         end
         inv_mass_ff    <= rbei_pkg::INV_SCALE_RST;
         inv_inertia_ff <= rbei_pkg::INV_SCALE_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (rbei_pkg::csr_idx_type'(csr_index))
               rbei_pkg::CSR_INV_MASS:    inv_mass_ff    <= csr_wdata[rbei_pkg::SCALE_W-1:0];
               rbei_pkg::CSR_INV_INERTIA: inv_inertia_ff <= csr_wdata[rbei_pkg::SCALE_W-1:0];
               rbei_pkg::CSR_START_X:     pos_ff[rbei_pkg::AXIS_X] <= csr_wdata;
               rbei_pkg::CSR_START_Y:     pos_ff[rbei_pkg::AXIS_Y] <= csr_wdata;
            endcase
         end

         // Accumulating actions finish on the transfer itself.
         if (ctl.capture) begin
            if (req_action == rbei_pkg::ACT_FORCE) begin
               frc_ff[rbei_pkg::AXIS_X] <= rbei_pkg::sat_add(frc_ff[rbei_pkg::AXIS_X],
                                                             req_bus.vec_x);
               frc_ff[rbei_pkg::AXIS_Y] <= rbei_pkg::sat_add(frc_ff[rbei_pkg::AXIS_Y],
                                                             req_bus.vec_y);
            end else if (req_action == rbei_pkg::ACT_TORQUE) begin
               frc_ff[rbei_pkg::AXIS_ROT] <= rbei_pkg::sat_add(frc_ff[rbei_pkg::AXIS_ROT],
                                                               req_bus.torque_in);
            end
         end

         if (ctl.wb) begin
            if (ctl.is_step) begin
               if (ctl.phase == rbei_pkg::PH_VEL) begin
                  vel_ff[ctl.axis] <= add_sum;
               end else if (ctl.phase == rbei_pkg::PH_POS) begin
                  pos_ff[ctl.axis] <= add_sum;
                  frc_ff[ctl.axis] <= '0;
               end
            end else if (ctl.phase == rbei_pkg::PH_KICK) begin
               vel_ff[ctl.axis] <= add_sum;
            end
         end

         if (ctl.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Operand holding, intermediate product and the result register.
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         dt_ff      <= req_bus.time_step;
         kick_ff[0] <= req_bus.vec_x;
         kick_ff[1] <= req_bus.vec_y;
      end
      if (ctl.wb && (ctl.phase == rbei_pkg::PH_SCALE)) begin
         tmp_ff <= mul_res;
      end
      if (ctl.load_rsp) begin
         rsp_pos_x_ff  <= pos_ff[rbei_pkg::AXIS_X];
         rsp_pos_y_ff  <= pos_ff[rbei_pkg::AXIS_Y];
         rsp_angle_ff  <= pos_ff[rbei_pkg::AXIS_ROT];
         rsp_vel_x_ff  <= vel_ff[rbei_pkg::AXIS_X];
         rsp_vel_y_ff  <= vel_ff[rbei_pkg::AXIS_Y];
         rsp_spin_ff   <= vel_ff[rbei_pkg::AXIS_ROT];
         rsp_static_ff <= body_static;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pos_x     = rsp_pos_x_ff;
   assign rsp_bus.pos_y     = rsp_pos_y_ff;
   assign rsp_bus.angle     = rsp_angle_ff;
   assign rsp_bus.vel_x     = rsp_vel_x_ff;
   assign rsp_bus.vel_y     = rsp_vel_y_ff;
   assign rsp_bus.spin      = rsp_spin_ff;
   assign rsp_bus.is_static = rsp_static_ff;

   // The block is busy in the cycle after every request transfer.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("request accepted on the cycle after a transfer");

   // A new result never overwrites one that has not been taken.
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("pending result overwritten");

   // An impulse on a static body leaves the velocity alone.
   a_static_impulse: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_action == rbei_pkg::ACT_IMPULSE) && body_static)
      |=> ($stable(vel_ff[rbei_pkg::AXIS_X]) && $stable(vel_ff[rbei_pkg::AXIS_Y])))
      else $error("static body velocity changed by impulse");

endmodule

`default_nettype wire

// ===== tb/tb_rigid_body_euler_integrator_core.sv =====
// Self-checking testbench for the 2D rigid body semi-implicit Euler integrator.
// Depends on rbei_pkg, the rbei_req_if/rbei_rsp_if interfaces and the core itself.
`timescale 1ns / 1ps

module tb_rigid_body_euler_integrator_core;
   import rbei_pkg::*;

   // The slowest legal quiet stretch is the long receiver hold-off plus a full step
   // and a few register writes, so this is many times the worst case.
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int TAIL_CYCLES      = 40;
   localparam int SETTLE_CYCLES    = 4;
   localparam int MAX_PRINTED      = 40;

   // One request item as the sender sees it.
   typedef struct {
      action_type                 action;
      logic signed [WORD_W-1:0]   vec_x;
      logic signed [WORD_W-1:0]   vec_y;
      logic signed [WORD_W-1:0]   torque_in;
      logic [DT_W-1:0]            time_step;
   } body_cmd_type;

   // The body state reported back after each item.
   typedef struct {
      logic signed [WORD_W-1:0]   pos_x;
      logic signed [WORD_W-1:0]   pos_y;
      logic signed [WORD_W-1:0]   angle;
      logic signed [WORD_W-1:0]   vel_x;
      logic signed [WORD_W-1:0]   vel_y;
      logic signed [WORD_W-1:0]   spin;
      logic                       is_static;
   } body_snap_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [WORD_W-1:0]      csr_wdata;

   rbei_req_if req_bus ();
   rbei_rsp_if rsp_bus ();

   rigid_body_euler_integrator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Items waiting to be offered, and body states waiting to be reported.
   body_cmd_type   cmd_queue [$];
   body_snap_type  pending_snapshots [$];

   // Predicted configuration and body state, updated on every register write and
   // on every accepted request transfer.
   logic [SCALE_W-1:0]         cfg_inv_mass;
   logic [SCALE_W-1:0]         cfg_inv_inertia;
   logic signed [WORD_W-1:0]   body_pos [2];
   logic signed [WORD_W-1:0]   body_vel [2];
   logic signed [WORD_W-1:0]   body_angle;
   logic signed [WORD_W-1:0]   body_spin;
   logic signed [WORD_W-1:0]   force_acc [2];
   logic signed [WORD_W-1:0]   torque_acc;

   // Handshake bookkeeping shared between the clocked processes.
   logic   req_taken;
   int     items_taken;
   int     error_count;
   int     quiet_cycles;
   int     send_idle_pct;
   int     recv_idle_pct;
   int     long_hold_at;
   int     hold_started_at;
   int     long_hold_left;

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Fixed-point arithmetic of the predictor.
   // ------------------------------------------------------------------------

   function automatic logic signed [WORD_W-1:0] clamp_word(longint v);
      if (v > longint'(WORD_MAX)) begin
         return WORD_MAX;
      end
      if (v < longint'(WORD_MIN)) begin
         return WORD_MIN;
      end
      return v[WORD_W-1:0];
   endfunction

   function automatic logic signed [WORD_W-1:0] add_clamped(longint a, longint b);
      return clamp_word(a + b);
   endfunction

   // Q16.16 product: the exact product plus one half, floored by the arithmetic
   // shift, which gives round to nearest with ties toward plus infinity.
   function automatic logic signed [WORD_W-1:0] q16_product(longint a, longint b);
      longint p;
      p = (a * b + 64'sd32768) >>> FRAC_W;
      return clamp_word(p);
   endfunction

   // Applies one accepted item to the predicted body and returns the state that
   // the block must report for it.
   function automatic body_snap_type apply_command(body_cmd_type cmd);
      body_snap_type              snap;
      logic signed [WORD_W-1:0]   accel;
      logic signed [WORD_W-1:0]   kick [2];
      logic                       moving;
      moving  = (cfg_inv_mass >= STATIC_LIMIT);
      kick[0] = cmd.vec_x;
      kick[1] = cmd.vec_y;
      case (cmd.action)
         ACT_FORCE: begin
            force_acc[0] = add_clamped(force_acc[0], cmd.vec_x);
            force_acc[1] = add_clamped(force_acc[1], cmd.vec_y);
         end
         ACT_TORQUE: begin
            torque_acc = add_clamped(torque_acc, cmd.torque_in);
         end
         ACT_STEP: begin
            // A static body keeps its accumulators as well as its motion.
            if (moving) begin
               for (int i = 0; i < 2; i++) begin
                  accel       = q16_product(force_acc[i], cfg_inv_mass);
                  body_vel[i] = add_clamped(body_vel[i], q16_product(accel, cmd.time_step));
                  body_pos[i] = add_clamped(body_pos[i],
                                            q16_product(body_vel[i], cmd.time_step));
                  force_acc[i] = '0;
               end
               accel      = q16_product(torque_acc, cfg_inv_inertia);
               body_spin  = add_clamped(body_spin, q16_product(accel, cmd.time_step));
               body_angle = add_clamped(body_angle, q16_product(body_spin, cmd.time_step));
               torque_acc = '0;
            end
         end
         ACT_IMPULSE: begin
            if (moving) begin
               for (int i = 0; i < 2; i++) begin
                  body_vel[i] = add_clamped(q16_product(body_vel[i], DAMP_Q16),
                                            q16_product(kick[i], cfg_inv_mass));
               end
            end
         end
      endcase
      snap.pos_x     = body_pos[0];
      snap.pos_y     = body_pos[1];
      snap.angle     = body_angle;
      snap.vel_x     = body_vel[0];
      snap.vel_y     = body_vel[1];
      snap.spin      = body_spin;
      snap.is_static = !moving;
      return snap;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------

   // Mostly modest magnitudes so that motion builds up without pinning at the
   // limits, with full-range words and the extremes mixed in.
   function automatic logic signed [WORD_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $signed($urandom_range(0, 2097152)) - 1048576;
         4, 5, 6:    return $urandom;
         7:          return WORD_MAX;
         8:          return WORD_MIN;
         default:    return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      endcase
   endfunction

   function automatic logic [DT_W-1:0] random_dt();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(0, 65535);
         6, 7:             return $urandom_range(1, 4096);
         8:                return '0;
         default:          return '1;
      endcase
   endfunction

   // Forces and torques build up, steps consume them and impulses kick the body.
   // Fields that an action does not use still carry random values.
   task automatic queue_random(int count);
      body_cmd_type  cmd;
      int            pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            cmd.action = ACT_FORCE;
         end else if (pick < 55) begin
            cmd.action = ACT_TORQUE;
         end else if (pick < 85) begin
            cmd.action = ACT_STEP;
         end else begin
            cmd.action = ACT_IMPULSE;
         end
         cmd.vec_x     = random_word();
         cmd.vec_y     = random_word();
         cmd.torque_in = random_word();
         cmd.time_step = random_dt();
         cmd_queue.push_back(cmd);
      end
   endtask

   task automatic queue_cmd(action_type act, logic signed [WORD_W-1:0] x,
                            logic signed [WORD_W-1:0] y, logic signed [WORD_W-1:0] tq,
                            logic [DT_W-1:0] dt);
      body_cmd_type cmd;
      cmd.action    = act;
      cmd.vec_x     = x;
      cmd.vec_y     = y;
      cmd.torque_in = tq;
      cmd.time_step = dt;
      cmd_queue.push_back(cmd);
   endtask

   // Returns once nothing has been queued, offered or outstanding for several
   // falling edges in a row, so an item popped on the same edge is still seen.
   task automatic wait_for_drain();
      int calm;
      calm = 0;
      while (calm < SETTLE_CYCLES) begin
         @(negedge clock);
         if (cmd_queue.size() != 0 || req_bus.valid || pending_snapshots.size() != 0) begin
            calm = 0;
         end else begin
            calm++;
         end
      end
   endtask

   // Register writes only happen while the block is idle, so the predictor can
   // take the new value at once. Start position writes also move the body.
   task automatic write_csr(csr_idx_type idx, logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_INV_MASS:    cfg_inv_mass    = data[SCALE_W-1:0];
         CSR_INV_INERTIA: cfg_inv_inertia = data[SCALE_W-1:0];
         CSR_START_X:     body_pos[0]     = data;
         CSR_START_Y:     body_pos[1]     = data;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                  logic [WORD_W-1:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("ERROR %0t: %s got %h, predicted %h", $realtime, what, got, want);
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver: a new item goes out at the falling edge once the previous
   // one was transferred, or when nothing is on offer. The idle draw only takes
   // place between items, so a presented item is never withdrawn.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      body_cmd_type  next_cmd;
      logic          offer;
      if (!reset && (!req_bus.valid || req_taken)) begin
         offer = (cmd_queue.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
         if (offer) begin
            next_cmd = cmd_queue.pop_front();
            req_bus.action    <= next_cmd.action;
            req_bus.vec_x     <= next_cmd.vec_x;
            req_bus.vec_y     <= next_cmd.vec_y;
            req_bus.torque_in <= next_cmd.torque_in;
            req_bus.time_step <= next_cmd.time_step;
         end
         req_bus.valid <= offer;
      end
   end

   // ------------------------------------------------------------------------
   // Result sink: random back-pressure, plus one long hold-off armed by the
   // stimulus through long_hold_at and counted down here, during which the
   // sender keeps offering so that the block backs up and stalls its input.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : rsp_sink
      logic take;
      if (long_hold_left == 0 && items_taken >= long_hold_at
          && hold_started_at != long_hold_at) begin
         hold_started_at = long_hold_at;
         long_hold_left  = LONG_HOLD_CYCLES;
      end
      if (long_hold_left != 0) begin
         long_hold_left--;
         take = 1'b0;
      end else begin
         take = ($urandom_range(0, 99) >= recv_idle_pct);
      end
      rsp_bus.ready <= !reset && take;
   end

   // ------------------------------------------------------------------------
   // Monitor: at each rising edge, a result transfer is checked against the
   // oldest prediction, and a request transfer is run through the predictor.
   // Reads here see the values from before the edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      body_cmd_type   taken_cmd;
      body_snap_type  want;
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_snapshots.size() == 0) begin
            report_mismatch("result with no item outstanding", rsp_bus.pos_x, '0);
         end else begin
            want = pending_snapshots.pop_front();
            if (rsp_bus.pos_x !== want.pos_x) report_mismatch("pos_x", rsp_bus.pos_x, want.pos_x);
            if (rsp_bus.pos_y !== want.pos_y) report_mismatch("pos_y", rsp_bus.pos_y, want.pos_y);
            if (rsp_bus.angle !== want.angle) report_mismatch("angle", rsp_bus.angle, want.angle);
            if (rsp_bus.vel_x !== want.vel_x) report_mismatch("vel_x", rsp_bus.vel_x, want.vel_x);
            if (rsp_bus.vel_y !== want.vel_y) report_mismatch("vel_y", rsp_bus.vel_y, want.vel_y);
            if (rsp_bus.spin !== want.spin) report_mismatch("spin", rsp_bus.spin, want.spin);
            if (rsp_bus.is_static !== want.is_static) begin
               report_mismatch("is_static", rsp_bus.is_static, want.is_static);
            end
         end
      end
      if (!reset && req_bus.valid && req_bus.ready) begin
         taken_cmd.action    = action_type'(req_bus.action);
         taken_cmd.vec_x     = req_bus.vec_x;
         taken_cmd.vec_y     = req_bus.vec_y;
         taken_cmd.torque_in = req_bus.torque_in;
         taken_cmd.time_step = req_bus.time_step;
         pending_snapshots.push_back(apply_command(taken_cmd));
         items_taken++;
      end
   end

   // Watchdog: ends the run if neither channel has moved for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("rigid_body_euler_integrator_core: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus sequence. Each phase sets a configuration while the block is
   // idle, then queues items; the driver and sink run on their own.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      // Every input known from time zero; the predictor starts at reset values.
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_INV_MASS;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.action    = ACT_FORCE;
      req_bus.vec_x     = '0;
      req_bus.vec_y     = '0;
      req_bus.torque_in = '0;
      req_bus.time_step = '0;
      rsp_bus.ready     = 1'b0;
      req_taken         = 1'b0;
      items_taken       = 0;
      error_count       = 0;
      quiet_cycles      = 0;
      long_hold_at      = 32'h7FFF_FFFF;
      hold_started_at   = -1;
      long_hold_left    = 0;
      cfg_inv_mass      = INV_SCALE_RST;
      cfg_inv_inertia   = INV_SCALE_RST;
      body_pos[0]       = '0;
      body_pos[1]       = '0;
      body_vel[0]       = '0;
      body_vel[1]       = '0;
      body_angle        = '0;
      body_spin         = '0;
      force_acc[0]      = '0;
      force_acc[1]      = '0;
      torque_acc        = '0;
      // Sender sparse and receiver very choppy first.
      send_idle_pct     = 34;
      recv_idle_pct     = 65;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items at the reset configuration: accumulators driven into
      // saturation from both sides, steps with zero, tiny and maximal dt,
      // impulses at the extremes, and fields that the action ignores.
      queue_cmd(ACT_FORCE, WORD_MAX, WORD_MIN, WORD_MIN, '1);
      queue_cmd(ACT_FORCE, WORD_MAX, WORD_MIN, WORD_MAX, '0);
      queue_cmd(ACT_TORQUE, WORD_MIN, WORD_MAX, WORD_MAX, '1);
      queue_cmd(ACT_TORQUE, WORD_MIN, WORD_MAX, WORD_MAX, '1);
      queue_cmd(ACT_STEP, WORD_MAX, WORD_MAX, WORD_MAX, '1);
      queue_cmd(ACT_STEP, WORD_MIN, WORD_MIN, WORD_MIN, '0);
      queue_cmd(ACT_IMPULSE, WORD_MIN, WORD_MAX, WORD_MIN, '1);
      queue_cmd(ACT_IMPULSE, '0, '0, WORD_MAX, '0);
      queue_cmd(ACT_FORCE, -32'sd1, 32'sd1, '0, 16'd1);
      queue_cmd(ACT_TORQUE, '0, '0, WORD_MIN, '0);
      queue_cmd(ACT_TORQUE, '0, '0, WORD_MIN, '0);
      queue_cmd(ACT_STEP, '0, '0, '0, 16'd1);
      queue_cmd(ACT_IMPULSE, WORD_MAX, WORD_MAX, '0, '1);
      queue_cmd(ACT_FORCE, 32'sh0001_0000, -32'sh0001_0000, '0, '0);
      queue_cmd(ACT_TORQUE, '0, '0, 32'sh0000_8000, '0);
      queue_cmd(ACT_STEP, '0, '0, '0, 16'd1092);
      queue_cmd(ACT_IMPULSE, 32'sh0000_0001, -32'sh0000_0001, '0, '0);
      queue_cmd(ACT_STEP, '0, '0, '0, 16'd32768);
      wait_for_drain();

      // Heaviest kick: largest inverse mass (the top data bit must be dropped),
      // zero inverse inertia so rotation coasts, and the start position at the
      // corners of the range.
      write_csr(CSR_INV_MASS, 32'hFFFF_FFFF);
      write_csr(CSR_INV_INERTIA, '0);
      write_csr(CSR_START_X, WORD_MAX);
      write_csr(CSR_START_Y, WORD_MIN);
      queue_random(60);
      wait_for_drain();

      // Just below the static limit: steps and impulses change nothing and the
      // accumulators are kept, while forces and torques still add up.
      write_csr(CSR_INV_MASS, 32'd327);
      write_csr(CSR_INV_INERTIA, 32'h7FFF_FFFF);
      write_csr(CSR_START_X, '0);
      write_csr(CSR_START_Y, '0);
      queue_cmd(ACT_FORCE, 32'sh0002_0000, -32'sh0003_0000, '0, '0);
      queue_cmd(ACT_TORQUE, '0, '0, 32'sh0001_0000, '0);
      queue_cmd(ACT_STEP, '0, '0, '0, 16'd4096);
      queue_cmd(ACT_IMPULSE, 32'sh0010_0000, 32'sh0010_0000, '0, '0);
      queue_random(50);
      wait_for_drain();

      // Swap the idle pattern: sender choppy, receiver mostly ready.
      send_idle_pct <= 65;
      recv_idle_pct <= 34;

      // Exactly at the limit the body moves again and releases what the static
      // phase accumulated.
      write_csr(CSR_INV_MASS, 32'd328);
      queue_random(60);
      wait_for_drain();

      // Zero inverse mass is static too.
      write_csr(CSR_INV_MASS, '0);
      queue_random(40);
      wait_for_drain();

      // Plausible body with the sender pausing halfway until every result is in.
      write_csr(CSR_INV_MASS, $urandom_range(328, 262144));
      write_csr(CSR_INV_INERTIA, $urandom_range(0, 262144));
      write_csr(CSR_START_X, random_word());
      write_csr(CSR_START_Y, random_word());
      queue_random(100);
      wait_for_drain();
      queue_random(100);
      wait_for_drain();

      // No idling on either side, fully random configuration, and one long
      // receiver hold-off while the sender keeps pushing.
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      write_csr(CSR_INV_MASS, $urandom);
      write_csr(CSR_INV_INERTIA, $urandom);
      write_csr(CSR_START_X, $urandom);
      write_csr(CSR_START_Y, $urandom);
      long_hold_at = items_taken + 20;
      queue_random(140);
      wait_for_drain();

      // Give a stray extra result time to show up before the verdict.
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("rigid_body_euler_integrator_core: match");
      end else begin
         $display("rigid_body_euler_integrator_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== rigid_body_euler_integrator_core.f =====
design/rbei_pkg.sv
design/rbei_req_if.sv
design/rbei_rsp_if.sv
design/rbei_mul.sv
design/rbei_seq.sv
design/rigid_body_euler_integrator_core.sv
tb/tb_rigid_body_euler_integrator_core.sv
